FILE: rtl/core/iia_pkg.sv
`timescale 1ns / 1ps

package iia_pkg;

  // Operation codes carried by the mode field
  typedef enum logic [3:0] {
    MODE_ADD       = 4'd0,
    MODE_SUB       = 4'd1,
    MODE_MUL       = 4'd2,
    MODE_DIV       = 4'd3,
    MODE_INTERSECT = 4'd4,
    MODE_RESTRICT_L = 4'd5,
    MODE_RESTRICT_R = 4'd6,
    MODE_CONTAINS  = 4'd7,
    MODE_EQUAL     = 4'd8
  } mode_e;

  // What the back end still has to do with an item
  typedef enum logic [1:0] {
    KIND_SIMPLE,
    KIND_MUL,
    KIND_DIV
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  flag;
  } ctrl_t;

  localparam int CTRL_W = $bits(ctrl_t);

endpackage

FILE: rtl/core/iia_fifo.sv
`timescale 1ns / 1ps

module iia_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wr_data,
  input  logic          pop,
  output logic [DW-1:0] rd_data,
  output logic          full,
  output logic          empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

FILE: rtl/core/iia_front.sv
`timescale 1ns / 1ps

module iia_front #(
  parameter int WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_mode,
  input  logic [63:0]       in_a_low,
  input  logic [63:0]       in_a_up,
  input  logic [63:0]       in_b_low,
  input  logic [63:0]       in_b_up,
  input  logic [63:0]       in_point,
  input  logic              q_full,
  output logic              q_push,
  output iia_pkg::ctrl_t    q_ctrl,
  output logic [WIDTH-1:0]  q_a,
  output logic [WIDTH-1:0]  q_b,
  output logic [WIDTH-1:0]  q_c,
  output logic [WIDTH-1:0]  q_d,
  output logic [WIDTH-1:0]  q_lo,
  output logic [WIDTH-1:0]  q_hi
);

  import iia_pkg::*;

  typedef struct packed {
    logic [WIDTH-1:0] lo;
    logic [WIDTH-1:0] hi;
  } ival_t;

  localparam logic [WIDTH-1:0] ONE  = WIDTH'(1);
  localparam logic [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};

  function automatic ival_t mk(input logic [WIDTH-1:0] lo, input logic [WIDTH-1:0] hi);
    ival_t r;
    if ($signed(hi) < $signed(lo)) begin
      r.lo = ONE;
      r.hi = '0;
    end else begin
      r.lo = lo;
      r.hi = hi;
    end
    return r;
  endfunction

  function automatic logic [WIDTH-1:0] smin(input logic [WIDTH-1:0] x,
                                             input logic [WIDTH-1:0] y);
    return ($signed(y) < $signed(x)) ? y : x;
  endfunction

  function automatic logic [WIDTH-1:0] smax(input logic [WIDTH-1:0] x,
                                             input logic [WIDTH-1:0] y);
    return ($signed(x) < $signed(y)) ? y : x;
  endfunction

  logic [WIDTH-1:0] al, au, bl, bu, pt, a, b, c, d;
  logic             a_emp, b_emp, any_emp, a_zero, b_zero;
  mode_e            mode;
  ival_t            res_nxt;
  ctrl_t            ctrl_nxt;

  logic             f_valid_r;
  ctrl_t            f_ctrl_r;
  logic [WIDTH-1:0] f_a_r, f_b_r, f_c_r, f_d_r, f_lo_r, f_hi_r;
  logic             load;

  assign mode = mode_e'(in_mode);
  assign al   = in_a_low[WIDTH-1:0];
  assign au   = in_a_up[WIDTH-1:0];
  assign bl   = in_b_low[WIDTH-1:0];
  assign bu   = in_b_up[WIDTH-1:0];
  assign pt   = in_point[WIDTH-1:0];

  // inverted bounds stand for the empty interval
  assign a_emp   = $signed(au) < $signed(al);
  assign b_emp   = $signed(bu) < $signed(bl);
  assign a       = a_emp ? ONE : al;
  assign b       = a_emp ? '0  : au;
  assign c       = b_emp ? ONE : bl;
  assign d       = b_emp ? '0  : bu;
  assign any_emp = a_emp || b_emp;
  assign a_zero  = ($signed(a) <= 0) && !b[WIDTH-1];
  assign b_zero  = ($signed(c) <= 0) && !d[WIDTH-1];

  always_comb begin
    res_nxt.lo    = ONE;
    res_nxt.hi    = '0;
    ctrl_nxt.kind = KIND_SIMPLE;
    ctrl_nxt.flag = 1'b0;
    unique case (mode)
      MODE_ADD: if (!any_emp) res_nxt = mk(a + c, b + d);
      MODE_SUB: if (!any_emp) res_nxt = mk(a - d, b - c);
      MODE_MUL: if (!any_emp) ctrl_nxt.kind = KIND_MUL;
      MODE_DIV: begin
        if (!any_emp) begin
          if (a_zero || b_zero) begin
            res_nxt.lo = MINV;
            res_nxt.hi = MAXV;
          end else begin
            ctrl_nxt.kind = KIND_DIV;
          end
        end
      end
      MODE_INTERSECT:  res_nxt = mk(smax(a, c), smin(b, d));
      MODE_RESTRICT_L: res_nxt = mk(a, smin(b, d));
      MODE_RESTRICT_R: res_nxt = mk(smax(a, c), b);
      MODE_CONTAINS:   ctrl_nxt.flag = ($signed(a) <= $signed(pt)) &&
                                       ($signed(pt) <= $signed(b));
      MODE_EQUAL:      ctrl_nxt.flag = (a == c) && (b == d);
      default: ;
    endcase
  end

  // hold the classified item until the queue takes it
  assign in_stall = f_valid_r && q_full;
  assign load     = !in_stall;
  assign q_push   = f_valid_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (load) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      f_ctrl_r <= ctrl_nxt;
      f_a_r    <= a;
      f_b_r    <= b;
      f_c_r    <= c;
      f_d_r    <= d;
      f_lo_r   <= res_nxt.lo;
      f_hi_r   <= res_nxt.hi;
    end
  end

  assign q_ctrl = f_ctrl_r;
  assign q_a    = f_a_r;
  assign q_b    = f_b_r;
  assign q_c    = f_c_r;
  assign q_d    = f_d_r;
  assign q_lo   = f_lo_r;
  assign q_hi   = f_hi_r;

endmodule

FILE: rtl/core/iia_back.sv
`timescale 1ns / 1ps

module iia_back #(
  parameter int WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  output logic              q_pop,
  input  iia_pkg::ctrl_t    q_ctrl,
  input  logic [WIDTH-1:0]  q_a,
  input  logic [WIDTH-1:0]  q_b,
  input  logic [WIDTH-1:0]  q_c,
  input  logic [WIDTH-1:0]  q_d,
  input  logic [WIDTH-1:0]  q_lo,
  input  logic [WIDTH-1:0]  q_hi,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_res_low,
  output logic [63:0]       out_res_up,
  output logic              out_flag
);

  import iia_pkg::*;

  localparam int NST = WIDTH + 4;
  localparam int H   = (WIDTH + 1) / 2;
  localparam int L   = WIDTH - H;

  localparam logic [WIDTH-1:0] ONE  = WIDTH'(1);
  localparam logic [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};

  function automatic logic [WIDTH-1:0] smin(input logic [WIDTH-1:0] x,
                                             input logic [WIDTH-1:0] y);
    return ($signed(y) < $signed(x)) ? y : x;
  endfunction

  function automatic logic [WIDTH-1:0] smax(input logic [WIDTH-1:0] x,
                                             input logic [WIDTH-1:0] y);
    return ($signed(x) < $signed(y)) ? y : x;
  endfunction

  function automatic logic [WIDTH-1:0] sat(input logic [WIDTH:0] v);
    return (v > {1'b0, MAXV}) ? MAXV : v[WIDTH-1:0];
  endfunction

  logic [NST-1:0]   v_r;
  logic             adv;

  ctrl_t            ctrl_r [0:WIDTH+1];
  logic [WIDTH-1:0] slo_r  [0:WIDTH+1];
  logic [WIDTH-1:0] shi_r  [0:WIDTH+1];

  logic [2*H-1:0]   mll_r  [0:3];
  logic [WIDTH-1:0] mhl_r  [0:3];
  logic [WIDTH-1:0] mlh_r  [0:3];
  logic [WIDTH-1:0] prod_r [1:WIDTH+1][0:3];

  logic [3:0]       sg_r   [0:WIDTH];
  logic [WIDTH-1:0] md_r   [0:WIDTH][0:3];
  logic [WIDTH-1:0] rem_r  [0:WIDTH][0:3];
  logic [WIDTH-1:0] nq_r   [0:WIDTH][0:3];

  logic [WIDTH-1:0] cx [0:3];
  logic [WIDTH-1:0] cy [0:3];
  logic [WIDTH-1:0] mid [0:3];
  logic [WIDTH-1:0] fl_c [0:3];
  logic [WIDTH-1:0] ce_c [0:3];
  logic [WIDTH-1:0] fl_r [0:3];
  logic [WIDTH-1:0] ce_r [0:3];

  logic [WIDTH-1:0] f2_lo_nxt, f2_hi_nxt, f2_lo_r, f2_hi_r;
  logic             f2_flag_r;
  logic [WIDTH-1:0] o_lo_r, o_hi_r;
  logic             o_flag_r;

  // the whole pipeline advances unless a finished result is held
  assign adv       = !v_r[NST-1] || !out_stall;
  assign q_pop     = adv && !q_empty;
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], !q_empty};
    end
  end

  // corners in the order a/c, a/d, b/c, b/d
  always_comb begin
    cx[0] = q_a; cy[0] = q_c;
    cx[1] = q_a; cy[1] = q_d;
    cx[2] = q_b; cy[2] = q_c;
    cx[3] = q_b; cy[3] = q_d;
  end

  // set-up stage: partial products and magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl_r[0] <= q_ctrl;
      slo_r[0]  <= q_lo;
      shi_r[0]  <= q_hi;
      for (int k = 0; k < 4; k++) begin
        mll_r[k]    <= cx[k][H-1:0] * cy[k][H-1:0];
        mhl_r[k]    <= cx[k][WIDTH-1:H] * cy[k][H-1:0];
        mlh_r[k]    <= cx[k][H-1:0] * cy[k][WIDTH-1:H];
        sg_r[0][k]  <= cx[k][WIDTH-1] ^ cy[k][WIDTH-1];
        md_r[0][k]  <= cy[k][WIDTH-1] ? '0 - cy[k] : cy[k];
        nq_r[0][k]  <= cx[k][WIDTH-1] ? '0 - cx[k] : cx[k];
        rem_r[0][k] <= '0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) mid[k] = mhl_r[k] + mlh_r[k];
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 1; j <= WIDTH; j++) begin : g_div
    logic [WIDTH-1:0] trial [0:3];
    logic [3:0]       ge;

    always_comb begin
      for (int k = 0; k < 4; k++) begin
        trial[k] = {rem_r[j-1][k][WIDTH-2:0], nq_r[j-1][k][WIDTH-1]};
        ge[k]    = trial[k] >= md_r[j-1][k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctrl_r[j] <= ctrl_r[j-1];
        slo_r[j]  <= slo_r[j-1];
        shi_r[j]  <= shi_r[j-1];
        sg_r[j]   <= sg_r[j-1];
        for (int k = 0; k < 4; k++) begin
          md_r[j][k]  <= md_r[j-1][k];
          rem_r[j][k] <= ge[k] ? trial[k] - md_r[j-1][k] : trial[k];
          nq_r[j][k]  <= {nq_r[j-1][k][WIDTH-2:0], ge[k]};
        end
      end
    end

    if (j == 1) begin : g_msum
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int k = 0; k < 4; k++) begin
            prod_r[1][k] <= mll_r[k][WIDTH-1:0] + {mid[k][L-1:0], {H{1'b0}}};
          end
        end
      end
    end else begin : g_mcarry
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int k = 0; k < 4; k++) prod_r[j][k] <= prod_r[j-1][k];
        end
      end
    end
  end

  // floor and ceiling of each exact quotient
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (!sg_r[WIDTH][k]) begin
        fl_c[k] = sat({1'b0, nq_r[WIDTH][k]});
        ce_c[k] = sat({1'b0, nq_r[WIDTH][k]} + (WIDTH+1)'(|rem_r[WIDTH][k]));
      end else begin
        fl_c[k] = '0 - (nq_r[WIDTH][k] + WIDTH'(|rem_r[WIDTH][k]));
        ce_c[k] = '0 - nq_r[WIDTH][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl_r[WIDTH+1] <= ctrl_r[WIDTH];
      slo_r[WIDTH+1]  <= slo_r[WIDTH];
      shi_r[WIDTH+1]  <= shi_r[WIDTH];
      for (int k = 0; k < 4; k++) begin
        prod_r[WIDTH+1][k] <= prod_r[WIDTH][k];
        fl_r[k]            <= fl_c[k];
        ce_r[k]            <= ce_c[k];
      end
    end
  end

  always_comb begin
    unique case (ctrl_r[WIDTH+1].kind)
      KIND_MUL: begin
        f2_lo_nxt = smin(smin(prod_r[WIDTH+1][0], prod_r[WIDTH+1][1]),
                         smin(prod_r[WIDTH+1][2], prod_r[WIDTH+1][3]));
        f2_hi_nxt = smax(smax(prod_r[WIDTH+1][0], prod_r[WIDTH+1][1]),
                         smax(prod_r[WIDTH+1][2], prod_r[WIDTH+1][3]));
      end
      KIND_DIV: begin
        f2_lo_nxt = smin(smin(fl_r[0], fl_r[1]), smin(fl_r[2], fl_r[3]));
        f2_hi_nxt = smax(smax(ce_r[0], ce_r[1]), smax(ce_r[2], ce_r[3]));
      end
      default: begin
        f2_lo_nxt = slo_r[WIDTH+1];
        f2_hi_nxt = shi_r[WIDTH+1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_lo_r   <= f2_lo_nxt;
      f2_hi_r   <= f2_hi_nxt;
      f2_flag_r <= ctrl_r[WIDTH+1].flag;
      o_flag_r  <= f2_flag_r;
      if ($signed(f2_hi_r) < $signed(f2_lo_r)) begin
        o_lo_r <= ONE;
        o_hi_r <= '0;
      end else begin
        o_lo_r <= f2_lo_r;
        o_hi_r <= f2_hi_r;
      end
    end
  end

  assign out_res_low = 64'($signed(o_lo_r));
  assign out_res_up  = 64'($signed(o_hi_r));
  assign out_flag    = o_flag_r;

  a_flag_empty : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flag |-> o_lo_r == ONE && o_hi_r == '0)
    else $error("flag set on a non-empty result");

  a_ordered : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($signed(o_hi_r) < $signed(o_lo_r)) |-> o_lo_r == ONE && o_hi_r == '0)
    else $error("inverted result not replaced by the empty interval");

  a_div_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[WIDTH] && ctrl_r[WIDTH].kind == KIND_DIV |->
      md_r[WIDTH][0] != '0 && md_r[WIDTH][1] != '0 &&
      md_r[WIDTH][2] != '0 && md_r[WIDTH][3] != '0)
    else $error("divide issued with a zero divisor");

endmodule

FILE: rtl/core/integer_interval_alu_core.sv
`timescale 1ns / 1ps

// Integer interval ALU. Each item carries two closed intervals A and B, a
// point and a mode; one result item (res_low, res_up, flag) comes back per
// input item, in order. One item is taken every cycle while in_stall is low. The
// back-end pipeline length is set by the bit-per-stage corner divider; every
// mode goes through the same fixed-length pipeline, so results never overtake
// one another. The front end classifies items and settles the simple modes; a
// small queue parts it from the back end, which does multiply and divide.

module integer_interval_alu_core #(
  parameter int WIDTH       = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [63:0] in_a_low,
  input  logic [63:0] in_a_up,
  input  logic [63:0] in_b_low,
  input  logic [63:0] in_b_up,
  input  logic [63:0] in_point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_res_low,
  output logic [63:0] out_res_up,
  output logic        out_flag
);

  import iia_pkg::*;

  localparam int IW = CTRL_W + 6 * WIDTH;

  // item between front and back: control, normalised bounds, simple result
  logic             q_push, q_pop, q_full, q_empty;
  ctrl_t            f_ctrl, b_ctrl;
  logic [WIDTH-1:0] f_a, f_b, f_c, f_d, f_lo, f_hi;
  logic [WIDTH-1:0] b_a, b_b, b_c, b_d, b_lo, b_hi;
  logic [IW-1:0]    q_wr, q_rd;

  iia_front #(.WIDTH(WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_a_low (in_a_low),
    .in_a_up  (in_a_up),
    .in_b_low (in_b_low),
    .in_b_up  (in_b_up),
    .in_point (in_point),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ctrl   (f_ctrl),
    .q_a      (f_a),
    .q_b      (f_b),
    .q_c      (f_c),
    .q_d      (f_d),
    .q_lo     (f_lo),
    .q_hi     (f_hi)
  );

  assign q_wr = {f_ctrl, f_a, f_b, f_c, f_d, f_lo, f_hi};

  // queue: lets front and back stall on their own
  iia_fifo #(.DW(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign {b_ctrl, b_a, b_b, b_c, b_d, b_lo, b_hi} = q_rd;

  iia_back #(.WIDTH(WIDTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_ctrl      (b_ctrl),
    .q_a         (b_a),
    .q_b         (b_b),
    .q_c         (b_c),
    .q_d         (b_d),
    .q_lo        (b_lo),
    .q_hi        (b_hi),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res_low (out_res_low),
    .out_res_up  (out_res_up),
    .out_flag    (out_flag)
  );

endmodule
